@@ hdl/mi3_pkg.sv @@
package mi3_pkg;

  localparam int ElemW = 32;
  localparam int CofW  = 64;
  localparam int DetW  = 98;
  localparam int DivW  = DetW + 32;
  localparam int QuoW  = 32;
  localparam int MulW  = 33;
  localparam int ProdW = 2 * MulW;

  localparam logic [3:0] LastIdx = 4'd8;

  typedef struct packed {
    logic [3:0]               element_index;
    logic signed [ElemW-1:0]  element_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]               out_index;
    logic signed [ElemW-1:0]  inverse_value;
    logic signed [ElemW-1:0]  det_value;
    logic                     singular;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic            ovf;
    logic [QuoW-1:0] quo;
  } div_res_t;

  // Element positions {a, b, c, d} of cofactor k = m[a]*m[b] - m[c]*m[d], one hex digit each.
  function automatic logic [15:0] cof_operands(input logic [3:0] k);
    logic [15:0] r;
    unique case (k)
      4'd0:    r = 16'h4857;
      4'd1:    r = 16'h2718;
      4'd2:    r = 16'h1524;
      4'd3:    r = 16'h5638;
      4'd4:    r = 16'h0826;
      4'd5:    r = 16'h2305;
      4'd6:    r = 16'h3746;
      4'd7:    r = 16'h1607;
      4'd8:    r = 16'h0413;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // Saturates a sign and magnitude to a signed 32-bit value; ovf flags a magnitude of 2^32 or more.
  function automatic logic [ElemW-1:0] sat32(input logic neg, input logic ovf,
                                             input logic [ElemW-1:0] mag);
    logic [ElemW-1:0] r;
    if (!neg) begin
      r = (ovf || mag[ElemW-1]) ? {1'b0, {(ElemW-1){1'b1}}} : mag;
    end else begin
      r = (ovf || mag > {1'b1, {(ElemW-1){1'b0}}}) ? {1'b1, {(ElemW-1){1'b0}}} : (~mag + 1'b1);
    end
    return r;
  endfunction

endpackage

@@ hdl/matrix_inverse_3x3_unit.sv @@
// 3x3 matrix inverse by the adjugate, in signed fixed point with FRAC_BITS fraction bits.
// Items load one matrix element each and are taken while the block is idle; an item with
// index 8 stores the last element and starts an inversion, and indexes above 8 are dropped.
// The inversion forms the nine exact cofactors with one shared, registered 33x33 multiplier,
// the exact determinant by expansion along the first row, and then each inverse element with
// one restoring divider, one element at a time; each result is handed over through the emit
// state to the output register. A singular matrix skips the divisions. The block takes no
// new item until the ninth result has been loaded into the output register.
module matrix_inverse_3x3_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mi3_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mi3_pkg::out_item_t  out_data_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COF     = 3'd1;
  localparam logic [2:0] S_DET     = 3'd2;
  localparam logic [2:0] S_DIVGO   = 3'd3;
  localparam logic [2:0] S_DIVWAIT = 3'd4;
  localparam logic [2:0] S_EMIT    = 3'd5;

  logic [2:0]                         state_q;
  logic [mi3_pkg::ElemW-1:0]          mat_q [9];
  logic [mi3_pkg::CofW-1:0]           cof_q [9];
  logic signed [mi3_pkg::DetW-1:0]    det_q;
  logic [4:0]                         op_q;
  logic                               ph_q;
  logic [3:0]                         k_q;
  logic [mi3_pkg::CofW-1:0]           tmp_q;
  logic [mi3_pkg::ElemW-1:0]          inv_q;
  mi3_pkg::out_item_t                 out_q;
  logic                               out_valid_q;

  // Operand selection for the shared multiplier.
  logic [15:0]                        opsel;
  logic [3:0]                         ia, ib, cidx;
  logic [1:0]                         row;
  logic [mi3_pkg::CofW-1:0]           cof_rd;
  logic signed [mi3_pkg::MulW-1:0]    mul_a, mul_b;
  logic signed [mi3_pkg::ProdW-1:0]   prod;

  always_comb begin
    opsel = mi3_pkg::cof_operands(op_q[4:1]);
    row   = op_q[2:1];
    ia    = op_q[0] ? opsel[7:4] : opsel[15:12];
    ib    = op_q[0] ? opsel[3:0] : opsel[11:8];
    case (row)
      2'd0:    cidx = 4'd0;
      2'd1:    cidx = 4'd3;
      default: cidx = 4'd6;
    endcase
    if (state_q == S_DET) begin
      ia = {2'b00, row};
    end else if (state_q != S_COF) begin
      cidx = k_q;
    end
    cof_rd = cof_q[cidx];
    mul_a  = $signed({mat_q[ia][mi3_pkg::ElemW-1], mat_q[ia]});
    if (state_q == S_DET) begin
      // Low word unsigned, high word signed: the 32x64 product in two partial products.
      mul_b = op_q[0] ? $signed({cof_rd[mi3_pkg::CofW-1], cof_rd[mi3_pkg::CofW-1:32]})
                      : $signed({1'b0, cof_rd[31:0]});
    end else begin
      mul_b = $signed({mat_q[ib][mi3_pkg::ElemW-1], mat_q[ib]});
    end
  end

  mi3_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Determinant magnitude, its Q16.16 view and the singular flag.
  logic                        sing, dneg;
  logic [mi3_pkg::DetW-1:0]    dmag, detq;
  logic [mi3_pkg::ElemW-1:0]   detbits;

  assign sing    = det_q == '0;
  assign dneg    = det_q[mi3_pkg::DetW-1];
  assign dmag    = dneg ? (~det_q + 1'b1) : det_q;
  assign detq    = dmag >> (2 * FRAC_BITS);
  assign detbits = sing ? '0 : mi3_pkg::sat32(dneg, |detq[mi3_pkg::DetW-1:32], detq[31:0]);

  // Numerator for the current inverse element: |cofactor| scaled by 2^(2*FRAC_BITS).
  logic [mi3_pkg::CofW-1:0]    cmag;
  logic [mi3_pkg::DivW-1:0]    num;
  logic                        div_start, div_done;
  mi3_pkg::div_res_t           div_res;

  assign cmag      = cof_rd[mi3_pkg::CofW-1] ? (~cof_rd + 1'b1) : cof_rd;
  assign num       = mi3_pkg::DivW'({cmag, {(2 * FRAC_BITS){1'b0}}});
  assign div_start = state_q == S_DIVGO && !sing;

  mi3_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (dmag),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  logic in_acc, out_free;
  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      ph_q        <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      det_q       <= '0;
      for (int i = 0; i < 9; i++) begin
        mat_q[i] <= '0;
      end
    end else begin
      // The output register fills from the emit state and empties when its item is taken.
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_data_i.element_index <= mi3_pkg::LastIdx) begin
            mat_q[in_data_i.element_index] <= in_data_i.element_value;
            if (in_data_i.element_index == mi3_pkg::LastIdx) begin
              state_q <= S_COF;
              op_q    <= '0;
              ph_q    <= 1'b0;
            end
          end
        end
        S_COF: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (op_q == 5'd17) begin
              state_q <= S_DET;
              op_q    <= '0;
              det_q   <= '0;
            end else begin
              op_q <= op_q + 1'b1;
            end
          end
        end
        S_DET: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            if (op_q[0]) begin
              det_q <= det_q + $signed({prod, 32'b0});
            end else begin
              det_q <= det_q + mi3_pkg::DetW'(prod);
            end
            if (op_q == 5'd5) begin
              state_q <= S_DIVGO;
              k_q     <= '0;
            end else begin
              op_q <= op_q + 1'b1;
            end
          end
        end
        S_DIVGO: begin
          state_q <= sing ? S_EMIT : S_DIVWAIT;
        end
        S_DIVWAIT: begin
          if (div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (k_q == mi3_pkg::LastIdx) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_DIVGO;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers: cofactors, partial product, inverse element and the outgoing item.
  always_ff @(posedge clk_i) begin
    if (state_q == S_COF && ph_q) begin
      if (op_q[0]) begin
        cof_q[op_q[4:1]] <= tmp_q - prod[mi3_pkg::CofW-1:0];
      end else begin
        tmp_q <= prod[mi3_pkg::CofW-1:0];
      end
    end
    if (state_q == S_DIVGO) begin
      inv_q <= '0;
    end else if (state_q == S_DIVWAIT && div_done) begin
      inv_q <= mi3_pkg::sat32(cof_rd[mi3_pkg::CofW-1] ^ dneg, div_res.ovf, div_res.quo);
    end
    if (state_q == S_EMIT && out_free) begin
      out_q.out_index     <= k_q;
      out_q.inverse_value <= inv_q;
      out_q.det_value     <= detbits;
      out_q.singular      <= sing;
      out_q.last          <= k_q == mi3_pkg::LastIdx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/mi3_mul.sv @@
module mi3_mul (
  input  logic                                 clk_i,
  input  logic signed [mi3_pkg::MulW-1:0]      a_i,
  input  logic signed [mi3_pkg::MulW-1:0]      b_i,
  output logic signed [mi3_pkg::ProdW-1:0]     p_o
);

  logic signed [mi3_pkg::ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

@@ hdl/mi3_div.sv @@
module mi3_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mi3_pkg::DivW-1:0]      num_i,
  input  logic [mi3_pkg::DetW-1:0]      den_i,
  output logic                          done_o,
  output mi3_pkg::div_res_t             res_o
);

  logic [mi3_pkg::DivW-1:0] rem_q, dd_q;
  logic [5:0]               cnt_q;
  logic                     busy_q, done_q, ovf_q;
  logic [mi3_pkg::QuoW-1:0] quo_q;
  logic                     ge;

  assign ge = rem_q >= dd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && cnt_q == '0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // The first step only checks whether the quotient reaches 2^32; the other 32 each give one bit.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dd_q  <= {den_i, {mi3_pkg::QuoW{1'b0}}};
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dd_q <= dd_q >> 1;
      if (cnt_q == 6'd32) begin
        ovf_q <= ge;
      end else begin
        quo_q <= {quo_q[mi3_pkg::QuoW-2:0], ge};
        if (ge) begin
          rem_q <= rem_q - dd_q;
        end
      end
    end
  end

  assign done_o    = done_q;
  assign res_o.ovf = ovf_q;
  assign res_o.quo = quo_q;

endmodule
